>>> rtl/core/pcst_pkg.sv
// shared types, codes and constants for the peer connection state table
// depends on nothing; used by pcst_entry_ram and peer_connection_state_table

package pcst_pkg;

    localparam int MAC_W           = 48;
    localparam int TIME_W          = 48;
    localparam int DL_W            = 49;
    localparam int TO_W            = 32;
    localparam int MAX_ENTRIES_DEF = 16;

    localparam logic [TO_W-1:0] TIMEOUT_RESET = 32'd60000;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_EVENT = 2'd2,
        CMD_CHECK = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        EVT_PRIVATE_ACK  = 2'd0,
        EVT_VLAN_ACK     = 2'd1,
        EVT_BACKHAUL_ACK = 2'd2,
        EVT_DISCONNECT   = 2'd3
    } evt_kind_t;

    typedef enum logic [1:0] {
        CONN_DISC     = 2'd0,
        CONN_DETECTED = 2'd1,
        CONN_VLAN     = 2'd2,
        CONN_FULL     = 2'd3
    } conn_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NOT_FOUND = 3'd1,
        STS_FULL      = 3'd2,
        STS_TIMED_OUT = 3'd3,
        STS_NONE      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } fsm_t;

    // one table entry as stored in the entry memory
    typedef struct packed {
        logic [MAC_W-1:0] mac;
        conn_t            conn;
        logic [DL_W-1:0]  deadline;
    } entry_t;

    // one result item
    typedef struct packed {
        status_t          status;
        logic [MAC_W-1:0] mac;
        conn_t            new_state;
    } result_t;

endpackage

>>> rtl/core/pcst_entry_ram.sv
// entry memory of the peer connection state table: one write port, one read port
// read data registered; depends on pcst_pkg for entry_t

module pcst_entry_ram #(
    parameter int DEPTH = pcst_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  pcst_pkg::entry_t wr_data,
    input  logic [AW-1:0]    rd_addr,
    output pcst_pkg::entry_t rd_data
);

    pcst_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/peer_connection_state_table.sv
// top level of the peer connection state table: command sequencer, scan control, output register
// depends on pcst_pkg and pcst_entry_ram
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  in       | in_valid / in_stall       | command, mac, event_kind, now_ms
//  out      | out_valid / out_stall     | status, mac_res, new_state, last
//  cfg      | cfg_valid / cfg_ready     | cfg_data (timeout_ms)
//
// add, clear and any item on an empty table go straight to emit; event and check scan first,
//   one entry read per cycle in the scan unless out_stall holds it (single read port sets this)
// a check with several timed-out entries also waits on out_stall for each transfer
// reset empties the table through the fill count alone, no clearing pass
// one item is worked on at a time; in_stall is high until its last result is in the
//   output register, which may still be waiting while the next item is taken

module peer_connection_state_table #(
    parameter int MAX_ENTRIES = pcst_pkg::MAX_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // item channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  command,
    input  logic [pcst_pkg::MAC_W-1:0]  mac,
    input  logic [1:0]                  event_kind,
    input  logic [pcst_pkg::TIME_W-1:0] now_ms,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  status,
    output logic [pcst_pkg::MAC_W-1:0]  mac_res,
    output logic [1:0]                  new_state,
    output logic                        last,
    // timeout register write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pcst_pkg::TO_W-1:0]   cfg_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    // control state
    pcst_pkg::fsm_t              state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            scan_idx_reg, scan_idx_next;
    logic [pcst_pkg::TO_W-1:0]   timeout_reg, timeout_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic                        out_valid_reg, out_valid_next;

    // payload holding
    pcst_pkg::cmd_t              item_cmd_reg;
    logic [pcst_pkg::MAC_W-1:0]  item_mac_reg;
    pcst_pkg::evt_kind_t         item_kind_reg;
    logic [pcst_pkg::TIME_W-1:0] item_now_reg;
    pcst_pkg::result_t           pend_reg, pend_next;
    pcst_pkg::result_t           out_reg, out_next;
    logic                        out_last_reg, out_last_next;

    // control from the output block
    logic                        item_load;
    logic                        pend_load;
    logic                        out_load;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    pcst_pkg::entry_t            wr_data;
    logic [IDX_W-1:0]            rd_addr;
    pcst_pkg::entry_t            rd_data;

    // shared decode
    logic                        in_fire;
    logic                        out_free;
    logic                        is_check;
    logic                        hit_chk;
    logic                        hit_evt;
    logic                        hold;
    logic                        scan_end;
    logic                        has_room;
    pcst_pkg::conn_t             evt_state;
    logic [pcst_pkg::DL_W-1:0]   evt_deadline;

    pcst_entry_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign has_room  = count_reg < CNT_MAX;
    assign is_check  = item_cmd_reg == pcst_pkg::CMD_CHECK;

    // timeout test on the entry just read: half-connected and deadline reached
    assign hit_chk = (rd_data.conn == pcst_pkg::CONN_DETECTED ||
                      rd_data.conn == pcst_pkg::CONN_VLAN) &&
                     ({1'b0, item_now_reg} >= rd_data.deadline);
    assign hit_evt = rd_data.mac == item_mac_reg;

    // a second timed-out entry needs the output register for the one held back
    assign hold = is_check && hit_chk && pend_valid_reg && !out_free;

    // entry under evaluation is the last valid one
    assign scan_end = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg;

    // event transition
    always_comb
    begin
        evt_deadline = '0;
        unique case (item_kind_reg)
            pcst_pkg::EVT_PRIVATE_ACK:
            begin
                evt_state    = pcst_pkg::CONN_DETECTED;
                evt_deadline = {1'b0, item_now_reg}
                             + {{(pcst_pkg::DL_W - pcst_pkg::TO_W){1'b0}}, timeout_reg};
            end
            pcst_pkg::EVT_VLAN_ACK:
            begin
                evt_state    = pcst_pkg::CONN_VLAN;
                evt_deadline = {1'b0, item_now_reg}
                             + {{(pcst_pkg::DL_W - pcst_pkg::TO_W){1'b0}}, timeout_reg};
            end
            pcst_pkg::EVT_BACKHAUL_ACK:
            begin
                evt_state = pcst_pkg::CONN_FULL;
            end
            pcst_pkg::EVT_DISCONNECT:
            begin
                evt_state = pcst_pkg::CONN_DISC;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pcst_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (pcst_pkg::cmd_t'(command) == pcst_pkg::CMD_ADD ||
                        pcst_pkg::cmd_t'(command) == pcst_pkg::CMD_CLEAR ||
                        count_reg == '0)
                    begin
                        state_next = pcst_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = pcst_pkg::ST_SCAN;
                    end
                end
            end
            pcst_pkg::ST_SCAN:
            begin
                if (!hold && ((!is_check && hit_evt) || scan_end))
                begin
                    state_next = pcst_pkg::ST_EMIT;
                end
            end
            pcst_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = pcst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcst_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        in_stall        = 1'b1;
        item_load       = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = scan_idx_reg;
        wr_data         = rd_data;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        pend_load       = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_load        = 1'b0;
        out_next        = pend_reg;
        out_last_next   = 1'b1;

        unique case (state_reg)
            pcst_pkg::ST_IDLE:
            begin
                in_stall      = 1'b0;
                scan_idx_next = '0;
                if (in_fire)
                begin
                    item_load       = 1'b1;
                    pend_load       = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_next       = '{status: pcst_pkg::STS_OK, mac: '0,
                                        new_state: pcst_pkg::CONN_DISC};
                    unique case (pcst_pkg::cmd_t'(command))
                        pcst_pkg::CMD_ADD:
                        begin
                            pend_next.mac = mac;
                            if (has_room)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[IDX_W-1:0];
                                wr_data    = '{mac: mac, conn: pcst_pkg::CONN_DISC,
                                               deadline: '0};
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                pend_next.status = pcst_pkg::STS_FULL;
                            end
                        end
                        pcst_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        pcst_pkg::CMD_EVENT:
                        begin
                            pend_next.status = pcst_pkg::STS_NOT_FOUND;
                        end
                        pcst_pkg::CMD_CHECK:
                        begin
                            // nothing held yet unless the table is empty
                            pend_next.status = pcst_pkg::STS_NONE;
                            pend_valid_next  = count_reg == '0;
                        end
                    endcase
                end
            end
            pcst_pkg::ST_SCAN:
            begin
                rd_addr = hold ? scan_idx_reg : scan_idx_reg + IDX_W'(1);
                if (!hold)
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
                if (is_check)
                begin
                    if (hit_chk && !hold)
                    begin
                        wr_en   = 1'b1;
                        wr_data = '{mac: rd_data.mac, conn: pcst_pkg::CONN_DISC,
                                    deadline: '0};
                        // the held entry is not the final one: send it on
                        out_load        = pend_valid_reg;
                        out_last_next   = 1'b0;
                        pend_load       = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_next       = '{status: pcst_pkg::STS_TIMED_OUT,
                                            mac: rd_data.mac,
                                            new_state: pcst_pkg::CONN_DISC};
                    end
                    else if (!hit_chk && scan_end && !pend_valid_reg)
                    begin
                        pend_load       = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_next       = '{status: pcst_pkg::STS_NONE, mac: '0,
                                            new_state: pcst_pkg::CONN_DISC};
                    end
                end
                else if (hit_evt)
                begin
                    wr_en           = 1'b1;
                    wr_data         = '{mac: rd_data.mac, conn: evt_state,
                                        deadline: evt_deadline};
                    pend_load       = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_next       = '{status: pcst_pkg::STS_OK, mac: rd_data.mac,
                                        new_state: evt_state};
                end
                // no match by the end keeps the not-found result loaded at accept
            end
            pcst_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_last_next   = 1'b1;
                    pend_load       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        timeout_next = timeout_reg;
        if (cfg_valid && cfg_ready)
        begin
            timeout_next = cfg_data;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pcst_pkg::ST_IDLE;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            timeout_reg    <= pcst_pkg::TIMEOUT_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            timeout_reg   <= timeout_next;
            out_valid_reg <= out_valid_next;
            if (pend_load)
            begin
                pend_valid_reg <= pend_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            item_cmd_reg  <= pcst_pkg::cmd_t'(command);
            item_mac_reg  <= mac;
            item_kind_reg <= pcst_pkg::evt_kind_t'(event_kind);
            item_now_reg  <= now_ms;
        end
        if (pend_load)
        begin
            pend_reg <= pend_next;
        end
        if (out_load)
        begin
            out_reg      <= out_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_reg.status;
    assign mac_res   = out_reg.mac;
    assign new_state = out_reg.new_state;
    assign last      = out_last_reg;

    // fill count stays within the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("entry count beyond table size");

    // a scan is only started on a non-empty table
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pcst_pkg::ST_SCAN |-> count_reg != '0)
        else $error("scan running on empty table");

    // write-back never hits the entry being read in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == pcst_pkg::ST_SCAN) |-> wr_addr != rd_addr)
        else $error("write-back collides with scan read");

    // a waiting result is never overwritten
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("output register overwritten while stalled");

    // the final result of an item is held when its transfer is due
    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pcst_pkg::ST_EMIT |-> pend_valid_reg)
        else $error("final result missing");

endmodule
